[sv/cst_pkg.sv]
// Package for the counting semaphore table: request and response beat types,
// request and status codes, and the count unit operation codes.
// No dependencies.
package cst_pkg;

  localparam int SlotW  = 7;
  localparam int InitW  = 15;
  localparam int TidW   = 8;
  localparam int ReqW   = 2;
  localparam int StatW  = 2;

  localparam logic [ReqW-1:0] REQ_CREATE = 2'd0;
  localparam logic [ReqW-1:0] REQ_P      = 2'd1;
  localparam logic [ReqW-1:0] REQ_V      = 2'd2;

  localparam logic [StatW-1:0] ST_OK   = 2'd0;
  localparam logic [StatW-1:0] ST_FULL = 2'd1;
  localparam logic [StatW-1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [SlotW-1:0] slot;
    logic [InitW-1:0] init_value;
    logic [TidW-1:0]  thread_id;
  } cst_req_t;

  typedef struct packed {
    logic [SlotW-1:0] granted_slot;
    logic [StatW-1:0] status;
    logic             must_block;
    logic             wake_one;
  } cst_rsp_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_DEC,
    OP_INC
  } cnt_op_e;

  typedef struct packed {
    logic sat;
    logic neg;
    logic nonpos;
  } cnt_flags_t;

endpackage

[sv/counting_semaphore_table_core.sv]
// Top level of the counting semaphore table: request sequencer, slot store
// and shared count unit. Depends on cst_pkg, cst_slot_mem, cst_count_alu.
//
//   port      dir  beat type   handshake
//   req_i     in   cst_req_t   taken at a clock edge with start high, busy low
//   rsp_o     out  cst_rsp_t   valid for one cycle while done_o is high
//
// P and V do one slot store read, then the count unit update and
// write-back. Create probes the slot store one entry per cycle from the
// rotating start, up to SLOTS entries. Other requests answer next cycle.
// After reset the store is cleared one entry a cycle, all SLOTS entries,
// with busy high. done_o is a one-cycle strobe; the receiver cannot stall it.
module counting_semaphore_table_core #(
  parameter int SLOTS          = 128,
  parameter int THREAD_ID_BITS = 8,
  parameter int COUNT_BITS     = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cst_pkg::cst_req_t req_i,
  output logic              done_o,
  output cst_pkg::cst_rsp_t rsp_o
);
  import cst_pkg::*;

  localparam int             IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PV,
    S_SCAN
  } state_e;

  state_e            state_q;
  cst_req_t          req_q;
  cst_rsp_t          rsp_q;
  logic              done_q;
  logic [IDX_W-1:0]  clr_q;
  logic [IDX_W-1:0]  probe_q;
  logic [IDX_W-1:0]  scan_cnt_q;
  logic [IDX_W-1:0]  search_start_q;

  logic [IDX_W-1:0]  probe_nxt;
  logic [IDX_W-1:0]  raddr;
  logic [IDX_W-1:0]  waddr;
  logic              we;
  logic              own_we;
  logic              wr_used;
  logic [COUNT_BITS-1:0] wr_count;
  logic              rd_used;
  logic [COUNT_BITS-1:0] rd_count;
  cnt_op_e           alu_op;
  logic [COUNT_BITS-1:0] alu_count;
  cnt_flags_t        alu_flags;
  logic              slot_ok;

  assign probe_nxt = (probe_q == LAST) ? '0 : probe_q + 1'b1;
  assign slot_ok   = (int'(req_i.slot) < SLOTS);

  always_comb begin
    raddr    = IDX_W'(req_i.slot);
    waddr    = clr_q;
    we       = 1'b0;
    own_we   = 1'b0;
    wr_used  = 1'b0;
    wr_count = '0;
    alu_op   = (req_q.req_type == REQ_P) ? OP_DEC : OP_INC;
    case (state_q)
      S_CLEAR: begin
        we = 1'b1;
      end
      S_IDLE: begin
        if (req_i.req_type == REQ_CREATE) begin
          raddr = search_start_q;
        end
      end
      S_PV: begin
        we       = 1'b1;
        waddr    = IDX_W'(req_q.slot);
        wr_used  = rd_used;
        wr_count = alu_count;
      end
      S_SCAN: begin
        raddr    = probe_nxt;
        alu_op   = OP_LOAD;
        waddr    = probe_q;
        we       = ~rd_used;
        own_we   = ~rd_used;
        wr_used  = 1'b1;
        wr_count = alu_count;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  cst_slot_mem #(
    .SLOTS          (SLOTS),
    .THREAD_ID_BITS (THREAD_ID_BITS),
    .COUNT_BITS     (COUNT_BITS),
    .IDX_W          (IDX_W)
  ) u_mem (
    .clk_i      (clk_i),
    .we_i       (we),
    .waddr_i    (waddr),
    .wr_used_i  (wr_used),
    .wr_count_i (wr_count),
    .own_we_i   (own_we),
    .own_data_i (THREAD_ID_BITS'(req_q.thread_id)),
    .raddr_i    (raddr),
    .rd_used_o  (rd_used),
    .rd_count_o (rd_count)
  );

  cst_count_alu #(
    .COUNT_BITS (COUNT_BITS)
  ) u_alu (
    .op_i    (alu_op),
    .count_i (rd_count),
    .init_i  (req_q.init_value),
    .count_o (alu_count),
    .flags_o (alu_flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      req_q          <= '0;
      rsp_q          <= '0;
      done_q         <= 1'b0;
      clr_q          <= '0;
      probe_q        <= '0;
      scan_cnt_q     <= '0;
      search_start_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == LAST) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            req_q <= req_i;
            rsp_q <= '{granted_slot: req_i.slot, status: ST_OK,
                       must_block: 1'b0, wake_one: 1'b0};
            case (req_i.req_type)
              REQ_CREATE: begin
                probe_q    <= search_start_q;
                scan_cnt_q <= '0;
                state_q    <= S_SCAN;
              end
              REQ_P, REQ_V: begin
                if (slot_ok) begin
                  state_q <= S_PV;
                end else begin
                  done_q <= 1'b1;
                end
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end
        S_PV: begin
          done_q             <= 1'b1;
          rsp_q.granted_slot <= req_q.slot;
          rsp_q.status       <= alu_flags.sat ? ST_SAT : ST_OK;
          rsp_q.must_block   <= (alu_op == OP_DEC) & alu_flags.neg;
          rsp_q.wake_one     <= (alu_op == OP_INC) & alu_flags.nonpos;
          state_q            <= S_IDLE;
        end
        S_SCAN: begin
          if (!rd_used) begin
            done_q             <= 1'b1;
            rsp_q.granted_slot <= SlotW'(probe_q);
            rsp_q.status       <= alu_flags.sat ? ST_SAT : ST_OK;
            search_start_q     <= probe_nxt;
            state_q            <= S_IDLE;
          end else if (scan_cnt_q == LAST) begin
            done_q       <= 1'b1;
            rsp_q.status <= ST_FULL;
            state_q      <= S_IDLE;
          end else begin
            probe_q    <= probe_nxt;
            scan_cnt_q <= scan_cnt_q + 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

[sv/cst_slot_mem.sv]
// Slot store: one entry per semaphore holding the in-use bit and the count,
// plus a write-only owner array. One write port, one registered read port.
// Depends on nothing but its parameters.
module cst_slot_mem #(
  parameter int SLOTS          = 128,
  parameter int THREAD_ID_BITS = 8,
  parameter int COUNT_BITS     = 16,
  parameter int IDX_W          = $clog2(SLOTS)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [IDX_W-1:0]          waddr_i,
  input  logic                      wr_used_i,
  input  logic [COUNT_BITS-1:0]     wr_count_i,
  input  logic                      own_we_i,
  input  logic [THREAD_ID_BITS-1:0] own_data_i,
  input  logic [IDX_W-1:0]          raddr_i,
  output logic                      rd_used_o,
  output logic [COUNT_BITS-1:0]     rd_count_o
);

  logic [COUNT_BITS:0]     ent_mem [SLOTS];
  logic [THREAD_ID_BITS-1:0] own_mem [SLOTS];
  logic [COUNT_BITS:0]     rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      ent_mem[waddr_i] <= {wr_used_i, wr_count_i};
    end
    if (own_we_i) begin
      own_mem[waddr_i] <= own_data_i;
    end
    rd_q <= ent_mem[raddr_i];
  end

  assign rd_used_o  = rd_q[COUNT_BITS];
  assign rd_count_o = rd_q[COUNT_BITS-1:0];

endmodule

[sv/cst_count_alu.sv]
// Shared count unit: saturating load, decrement and increment of a signed
// count with block and wake flags. Depends on cst_pkg.
module cst_count_alu #(
  parameter int COUNT_BITS = 16
) (
  input  cst_pkg::cnt_op_e              op_i,
  input  logic [COUNT_BITS-1:0]         count_i,
  input  logic [cst_pkg::InitW-1:0]     init_i,
  output logic [COUNT_BITS-1:0]         count_o,
  output cst_pkg::cnt_flags_t           flags_o
);
  import cst_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
  localparam int CMP_W = ((COUNT_BITS > InitW) ? COUNT_BITS : InitW) + 1;

  logic [COUNT_BITS-1:0] step;
  logic [COUNT_BITS-1:0] sum;
  logic                  sat;

  always_comb begin
    step    = (op_i == OP_DEC) ? '1 : COUNT_BITS'(1);
    sum     = count_i + step;
    sat     = 1'b0;
    count_o = count_i;
    case (op_i)
      OP_LOAD: begin
        if (CMP_W'(init_i) > CMP_W'(CNT_MAX)) begin
          count_o = CNT_MAX;
          sat     = 1'b1;
        end else begin
          count_o = COUNT_BITS'(init_i);
        end
      end
      OP_DEC: begin
        if (count_i == CNT_MIN) begin
          sat = 1'b1;
        end else begin
          count_o = sum;
        end
      end
      OP_INC: begin
        if (count_i == CNT_MAX) begin
          sat = 1'b1;
        end else begin
          count_o = sum;
        end
      end
      default: begin
        count_o = count_i;
      end
    endcase
    flags_o.sat    = sat;
    flags_o.neg    = count_o[COUNT_BITS-1];
    flags_o.nonpos = count_o[COUNT_BITS-1] | (count_o == '0);
  end

endmodule

[bench/tb_counting_semaphore_table_core.sv]
// Testbench for counting_semaphore_table_core: directed and random request beats
// are checked against a scoreboard that tracks slot use, counts and the create pointer.
// Depends on cst_pkg and the counting_semaphore_table_core RTL.
module tb_counting_semaphore_table_core;
  import cst_pkg::*;

  localparam int SlotCount  = 128;
  localparam int CountW     = 16;
  localparam int CntMax     = (1 << (CountW - 1)) - 1;
  localparam int CntMin     = -CntMax - 1;
  localparam int RandomBeats = 1300;
  localparam int CycleLimit  = 1500000;
  localparam logic [ReqW-1:0] REQ_UNUSED = 2'd3;

  class sema_scoreboard;
    bit                       in_use [SlotCount];
    logic [TidW-1:0]          owner  [SlotCount];
    logic signed [CountW-1:0] level  [SlotCount];
    int                       probe;
    cst_rsp_t                 awaited_rsp [$];
    int errors;
    int checked;
    int n_create;
    int n_full;
    int n_sat;
    int n_block;
    int n_wake;

    function new();
      for (int i = 0; i < SlotCount; i++) begin
        in_use[i] = 1'b0;
        level[i]  = '0;
      end
      probe = 0;
    endfunction

    function cst_rsp_t predict_response(cst_req_t r);
      cst_rsp_t rsp;
      int       idx;
      int       c;
      bit       found;
      rsp              = '0;
      rsp.granted_slot = r.slot;
      rsp.status       = ST_OK;
      found            = 1'b0;
      idx              = 0;
      case (r.req_type)
        REQ_CREATE: begin
          for (int n = 0; n < SlotCount; n++) begin
            if (!found && !in_use[(probe + n) % SlotCount]) begin
              found = 1'b1;
              idx   = (probe + n) % SlotCount;
            end
          end
          if (found) begin
            in_use[idx] = 1'b1;
            owner[idx]  = r.thread_id;
            if (int'(r.init_value) > CntMax) begin
              level[idx] = CountW'(CntMax);
              rsp.status = ST_SAT;
            end else begin
              level[idx] = CountW'(r.init_value);
            end
            rsp.granted_slot = SlotW'(idx);
            probe = (idx + 1) % SlotCount;
            n_create++;
          end else begin
            rsp.status = ST_FULL;
            n_full++;
          end
        end
        REQ_P: begin
          c = int'(level[r.slot]);
          if (c <= CntMin) rsp.status = ST_SAT;
          else c = c - 1;
          rsp.must_block = (c < 0);
          level[r.slot]  = CountW'(c);
        end
        REQ_V: begin
          c = int'(level[r.slot]);
          if (c >= CntMax) rsp.status = ST_SAT;
          else c = c + 1;
          rsp.wake_one  = (c <= 0);
          level[r.slot] = CountW'(c);
        end
        default: ;
      endcase
      if (rsp.status == ST_SAT) n_sat++;
      if (rsp.must_block) n_block++;
      if (rsp.wake_one) n_wake++;
      return rsp;
    endfunction

    function void note_request(cst_req_t r);
      awaited_rsp.push_back(predict_response(r));
    endfunction

    function void check_response(cst_rsp_t got);
      cst_rsp_t exp;
      checked++;
      if (awaited_rsp.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected response: slot %0d status %0d block %0b wake %0b",
                   got.granted_slot, got.status, got.must_block, got.wake_one);
        return;
      end
      exp = awaited_rsp.pop_front();
      if (got.granted_slot !== exp.granted_slot || got.status !== exp.status ||
          got.must_block !== exp.must_block || got.wake_one !== exp.wake_one) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected slot %0d status %0d block %0b wake %0b",
                   exp.granted_slot, exp.status, exp.must_block, exp.wake_one);
          $display("          got      slot %0d status %0d block %0b wake %0b",
                   got.granted_slot, got.status, got.must_block, got.wake_one);
        end
      end
    endfunction

    function int outstanding();
      return awaited_rsp.size();
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  cst_req_t req_i;
  logic     done_o;
  cst_rsp_t rsp_o;

  sema_scoreboard sb;
  int unsigned    cycle_count;
  int unsigned    sent;

  counting_semaphore_table_core #(
    .SLOTS         (SlotCount),
    .THREAD_ID_BITS(TidW),
    .COUNT_BITS    (CountW)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_response(rsp_o);
  end

  function automatic cst_req_t make_req(logic [ReqW-1:0] kind, int slot, int init, int tid);
    cst_req_t r;
    r.req_type   = kind;
    r.slot       = SlotW'(slot);
    r.init_value = InitW'(init);
    r.thread_id  = TidW'(tid);
    return r;
  endfunction

  function automatic cst_req_t random_request();
    cst_req_t    r;
    int unsigned pick;
    pick         = $urandom_range(0, 99);
    r.slot       = SlotW'($urandom);
    r.thread_id  = TidW'($urandom);
    r.init_value = InitW'($urandom);
    if (pick < 15) r.req_type = REQ_CREATE;
    else if (pick < 55) r.req_type = REQ_P;
    else if (pick < 95) r.req_type = REQ_V;
    else r.req_type = REQ_UNUSED;
    case ($urandom_range(0, 7))
      0: r.init_value = InitW'(CntMax);
      1: r.init_value = InitW'($urandom_range(0, 3));
      2: r.slot = SlotW'($urandom_range(0, 3));
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(cst_req_t r, int unsigned gap);
    @(negedge clk_i);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    req_i = r;
    do @(posedge clk_i); while (busy);
    sb.note_request(r);
    sent++;
  endtask

  task automatic drain_responses();
    @(negedge clk_i);
    start = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
  endtask

  initial begin
    bit burst;
    sb          = new();
    sent        = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_request(make_req(REQ_CREATE, 0, 0, 0), 0);
    send_request(make_req(REQ_CREATE, 127, CntMax, 255), 3);
    send_request(make_req(REQ_V, 1, 0, 0), 0);
    send_request(make_req(REQ_P, 0, 0, 0), 1);
    send_request(make_req(REQ_V, 0, 0, 0), 0);
    send_request(make_req(REQ_V, 0, 0, 0), 2);
    send_request(make_req(REQ_P, 0, 0, 0), 0);
    send_request(make_req(REQ_UNUSED, 127, CntMax, 255), 0);
    send_request(make_req(REQ_UNUSED, 0, 0, 0), 5);
    send_request(make_req(REQ_P, 127, 0, 0), 0);
    send_request(make_req(REQ_V, 127, 0, 0), 0);
    send_request(make_req(REQ_CREATE, 85, 1, 8'haa), 0);
    send_request(make_req(REQ_V, 2, 0, 0), 0);
    send_request(make_req(REQ_P, 2, 0, 0), 0);
    send_request(make_req(REQ_P, 2, 0, 0), 0);

    send_request(make_req(REQ_P, 126, 0, 0), 0);
    send_request(make_req(REQ_V, 126, 0, 0), 0);
    drain_responses();

    burst = 1'b0;
    for (int i = 0; i < RandomBeats; i++) begin
      if (i % 60 == 0) burst = ($urandom_range(0, 2) == 0);
      if (i % 300 == 150) drain_responses();
      send_request(random_request(), burst ? 0 : $urandom_range(0, 15));
    end

    @(negedge clk_i);
    start = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("sent %0d request beats, checked %0d responses in %0d cycles",
             sent, sb.checked, cycle_count);
    $display("creates %0d, table full %0d, saturated %0d, block %0d, wake %0d",
             sb.n_create, sb.n_full, sb.n_sat, sb.n_block, sb.n_wake);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("errors %0d, left over %0d", sb.errors, sb.outstanding());
      $display("status: fail");
    end
    $finish;
  end

endmodule
